@@ design/hsce_pkg.sv @@
// Shared types and constants for the Hall capture speed estimator.
// No dependencies; every other design file imports this package.
package hsce_pkg;

  localparam int CAP_W    = 16;   // capture interval width
  localparam int CLK_W    = 28;   // clock_hz register width
  localparam int PRE_W    = 16;   // prescaler register width
  localparam int EPR_W    = 8;    // edges_per_rev register width
  localparam int CFG_W    = 28;   // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int SPEED_W  = 32;   // Q24.8 speed result
  localparam int CNT60_W  = CLK_W + 6;              // clock_hz * 60
  localparam int P1_W     = CAP_W + PRE_W + 1;      // count * (prescaler + 1)
  localparam int DEN_W    = P1_W + EPR_W;           // full divisor
  localparam int OUT_RAW_W = SPEED_W + 3 * CAP_W + 1;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST       = CLK_W'(84000000);
  localparam logic [PRE_W-1:0] PRESCALER_RST      = '0;
  localparam logic [CAP_W-1:0] COUNTER_PERIOD_RST = CAP_W'(65535);
  localparam logic [EPR_W-1:0] EDGES_PER_REV_RST  = EPR_W'(12);

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ,
    REG_PRESCALER,
    REG_COUNTER_PERIOD,
    REG_EDGES_PER_REV
  } cfg_idx_t;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_TICK    = 1'b1
  } item_cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch request, update edge/jump state
    logic mul1;       // count * (prescaler + 1), numerator
    logic mul2;       // times edges_per_rev, seed divider
    logic div_step;   // one restoring division step
    logic speed_wr;   // commit quotient to speed register
    logic out_load;   // load output register
  } hsce_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
  } hsce_stat_t;

endpackage

@@ design/hsce_ctrl.sv @@
// Controller state machine of the Hall capture speed estimator.
// Depends on hsce_pkg; drives hsce_dp through hsce_cmd_t.
module hsce_ctrl import hsce_pkg::*; #(
  parameter int STEPS = 42
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  hsce_stat_t stat,
  output hsce_cmd_t  cmd
);

  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_WR,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  logic                out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_tvalid;
    cmd.mul1     = (state_r == S_MUL1);
    cmd.mul2     = (state_r == S_MUL2);
    cmd.div_step = (state_r == S_DIV);
    cmd.speed_wr = (state_r == S_WR);
    cmd.out_load = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= stat.is_tick ? S_DONE : S_MUL1;
          end
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(STEPS - 1)) begin
            state_r <= S_WR;
          end
        end
        S_WR: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/hsce_dp.sv @@
// Datapath of the Hall capture speed estimator: configuration registers,
// edge/jump tracking, two-stage divisor multiply, restoring divider, output.
// Depends on hsce_pkg; sequenced by hsce_ctrl.
module hsce_dp import hsce_pkg::*; #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int NUM_W = CNT60_W + SPEED_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tuser,
  input  logic [CAP_W-1:0]       in_tdata,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  hsce_cmd_t              cmd,
  output hsce_stat_t             stat
);

  logic [CLK_W-1:0]   clock_hz_r;
  logic [PRE_W-1:0]   prescaler_r;
  logic [CAP_W-1:0]   counter_period_r;
  logic [EPR_W-1:0]   edges_per_rev_r;

  logic [SPEED_W-1:0] speed_r;
  logic               edge_seen_r;
  logic [CAP_W-1:0]   capture_r;
  logic [CAP_W-1:0]   prev_capture_r;
  logic [CAP_W-1:0]   jump_r;
  logic [CAP_W-1:0]   spike_r;

  logic [CAP_W-1:0]   sel_count_r;
  logic               zero_count_r;
  logic [P1_W-1:0]    prod1_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]   qr_r;
  logic [DEN_W-1:0]   rem_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [CAP_W-1:0]   cap;
  logic               is_spike;
  logic [CNT60_W-1:0] clk60;
  logic [DEN_W:0]     trial;
  logic               fits;
  logic [DEN_W-1:0]   rem_nxt;
  logic [SPEED_W-1:0] speed_nxt;

  assign cap          = in_tdata;
  assign stat.is_tick = (in_tuser == CMD_TICK);
  assign out_tdata    = out_tdata_r;

  assign is_spike = (cap < (prev_capture_r >> 1)) ||
                    ({1'b0, cap} > {prev_capture_r, 1'b0});

  // clock_hz * 60 as two shifted terms
  assign clk60 = {clock_hz_r, 6'b0} - {4'b0, clock_hz_r, 2'b0};

  // restoring division step: shift numerator MSB into the remainder
  assign trial   = {rem_r, qr_r[NUM_W-1]};
  assign fits    = (trial >= {1'b0, den_r});
  assign rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];

  // saturate quotient to 32 bits; zero count forces zero
  always_comb begin
    if (zero_count_r) begin
      speed_nxt = '0;
    end else if (|qr_r[NUM_W-1:SPEED_W]) begin
      speed_nxt = SPEED_MAX;
    end else begin
      speed_nxt = qr_r[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r       <= CLOCK_HZ_RST;
      prescaler_r      <= PRESCALER_RST;
      counter_period_r <= COUNTER_PERIOD_RST;
      edges_per_rev_r  <= EDGES_PER_REV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CLOCK_HZ:       clock_hz_r       <= cfg_wdata[CLK_W-1:0];
        REG_PRESCALER:      prescaler_r      <= cfg_wdata[PRE_W-1:0];
        REG_COUNTER_PERIOD: counter_period_r <= cfg_wdata[CAP_W-1:0];
        REG_EDGES_PER_REV:  edges_per_rev_r  <= cfg_wdata[EPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r        <= '0;
      edge_seen_r    <= 1'b0;
      capture_r      <= '0;
      prev_capture_r <= '0;
      jump_r         <= '0;
      spike_r        <= '0;
    end else begin
      if (cmd.accept) begin
        if (stat.is_tick) begin
          if (!edge_seen_r) begin
            speed_r <= '0;
          end
          edge_seen_r <= 1'b0;
        end else begin
          edge_seen_r    <= 1'b1;
          capture_r      <= cap;
          prev_capture_r <= cap;
          if (prev_capture_r != '0) begin
            jump_r <= (cap > prev_capture_r) ? cap - prev_capture_r
                                             : prev_capture_r - cap;
            if (is_spike) begin
              spike_r <= spike_r + CAP_W'(1);
            end
          end
        end
      end
      if (cmd.speed_wr) begin
        speed_r <= speed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      // fall back to the full counter period until a speed exists
      sel_count_r  <= (speed_r != '0) ? cap : counter_period_r;
      zero_count_r <= (speed_r != '0) ? (cap == '0) : (counter_period_r == '0);
    end
    if (cmd.mul1) begin
      prod1_r <= P1_W'(sel_count_r) * P1_W'({1'b0, prescaler_r} + (PRE_W + 1)'(1));
      num_r   <= NUM_W'(clk60) << SPEED_FRAC_BITS;
    end
    if (cmd.mul2) begin
      den_r <= DEN_W'(prod1_r) * DEN_W'(edges_per_rev_r);
      rem_r <= '0;
      qr_r  <= num_r;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      qr_r  <= {qr_r[NUM_W-2:0], fits};
    end
    if (cmd.out_load) begin
      out_tdata_r <= OUT_TDATA_W'({edge_seen_r, spike_r, jump_r, capture_r, speed_r});
    end
  end

endmodule

@@ design/hall_capture_speed_estimator.sv @@
// Hall capture speed estimator, top level.
// Sequence: a capture request is accepted, multiplied in two steps, divided in
// 34 + SPEED_FRAC_BITS restoring-divider steps, committed and loaded to the output;
// a tick goes from acceptance straight to the output load.
// A new request is accepted only when idle, once the previous result has been loaded into a free output.
// Reset (rst_n low, synchronous): configuration to defaults, state and output valid cleared.
module hall_capture_speed_estimator import hsce_pkg::*; #(
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CAP_W-1:0]       in_tdata,   // [15:0] capture_count
  input  logic                   in_tuser,   // [0] cmd: 0 capture, 1 tick
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] speed_rpm, [47:32] last_capture,
                                             // [63:48] capture_jump, [79:64] spike_total,
                                             // [80] edge_flag, upper bits zero
);

  // numerator clock_hz * 60 * 2^SPEED_FRAC_BITS sets the divider step count
  localparam int NUM_W = CNT60_W + SPEED_FRAC_BITS;

  hsce_cmd_t  cmd;
  hsce_stat_t stat;

  // sequence each request: accept, multiply, divide, commit, present
  hsce_ctrl #(
    .STEPS (NUM_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // hold configuration and estimator state; compute speed
  hsce_dp #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .NUM_W           (NUM_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ design/hsce_checker.sv @@
// Port-level checker for the Hall capture speed estimator, bound to the top.
// Depends on hsce_pkg.
module hsce_checker import hsce_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in work");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_RAW_W] == '0)
    else $error("result padding not zero");

endmodule

bind hall_capture_speed_estimator hsce_checker u_hsce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/hall_capture_speed_estimator_tb.sv @@
// Self-checking testbench for hall_capture_speed_estimator: directed start-up and
// register-extreme cases, then randomized motor-like capture traffic with idling.
// Depends on hsce_pkg and the design top level; needs no files or arguments.
module hall_capture_speed_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsce_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS_PER_SEGMENT = 225;

  // One expected result, laid out like out_tdata so a slice casts directly.
  typedef struct packed {
    logic               edge_seen;
    logic [CAP_W-1:0]   spikes;
    logic [CAP_W-1:0]   jump;
    logic [CAP_W-1:0]   last_capture;
    logic [SPEED_W-1:0] speed;
  } speed_reading_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [CAP_W-1:0]       in_tdata = '0;   // [15:0] capture_count
  logic                   in_tuser = 1'b0; // [0] cmd: 0 capture, 1 tick
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] speed_rpm, [47:32] last_capture,
                                           // [63:48] capture_jump, [79:64] spike_total,
                                           // [80] edge_flag, upper bits zero

  // Configuration as the block should hold it.
  logic [CLK_W-1:0]   set_clock_hz = CLOCK_HZ_RST;
  logic [PRE_W-1:0]   set_prescaler = PRESCALER_RST;
  logic [CAP_W-1:0]   set_period = COUNTER_PERIOD_RST;
  logic [EPR_W-1:0]   set_edges = EDGES_PER_REV_RST;

  // Estimator state as the block should hold it.
  logic [SPEED_W-1:0] est_speed = '0;
  logic               est_edge = 1'b0;
  logic [CAP_W-1:0]   est_capture = '0;
  logic [CAP_W-1:0]   est_prev = '0;
  logic [CAP_W-1:0]   est_jump = '0;
  logic [CAP_W-1:0]   est_spikes = '0;

  speed_reading_t pending_readings[$];
  int             mismatch_count = 0;
  int             requests_sent = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             cycle_count = 0;

  hall_capture_speed_estimator #(.SPEED_FRAC_BITS(FRAC_BITS)) DUT (.*);

  initial forever #10 clk = ~clk;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hall_capture_speed_estimator_tb: errors");
      $finish;
    end
  end

  // Speed in Q24.8 rpm for one interval count, truncated and saturated.
  function automatic logic [SPEED_W-1:0] rpm_from_count(logic [CAP_W-1:0] count);
    longint unsigned numer;
    longint unsigned denom;
    longint unsigned quot;
    if (count == '0) return '0;
    numer = (64'(set_clock_hz) * 64'd60) << FRAC_BITS;
    denom = 64'(count) * (64'(set_prescaler) + 64'd1) * 64'(set_edges);
    // A vanishing divisor saturates, as the restoring divider does.
    if (denom == 0) return SPEED_MAX;
    quot = numer / denom;
    if (quot > 64'(SPEED_MAX)) return SPEED_MAX;
    return quot[SPEED_W-1:0];
  endfunction

  // Advance the estimator state by one request and return the reading it yields.
  function automatic speed_reading_t advance_estimator(item_cmd_t cmd,
                                                       logic [CAP_W-1:0] count);
    speed_reading_t r;
    if (cmd == CMD_CAPTURE) begin
      est_edge = 1'b1;
      est_capture = count;
      // Jump and spike tracking only once a nonzero reference exists.
      if (est_prev != '0) begin
        est_jump = (count > est_prev) ? count - est_prev : est_prev - count;
        if (count < est_prev / 2 || {1'b0, count} > {est_prev, 1'b0}) est_spikes++;
      end
      est_prev = count;
      // From standstill, restart from the full counter period.
      est_speed = rpm_from_count((est_speed != '0) ? count : set_period);
    end else begin
      // No edge since the last tick: the motor counts as stopped.
      if (!est_edge) est_speed = '0;
      est_edge = 1'b0;
    end
    r.speed = est_speed;
    r.last_capture = est_capture;
    r.jump = est_jump;
    r.spikes = est_spikes;
    r.edge_seen = est_edge;
    return r;
  endfunction

  task automatic compare_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: stall at random, check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    speed_reading_t want;
    speed_reading_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = speed_reading_t'(out_tdata[OUT_RAW_W-1:0]);
      if (pending_readings.size() == 0) begin
        $error("result with nothing expected: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("speed_rpm", want.speed, got.speed);
        compare_field("last_capture", want.last_capture, got.last_capture);
        compare_field("capture_jump", want.jump, got.jump);
        compare_field("spike_total", want.spikes, got.spikes);
        compare_field("edge_flag", want.edge_seen, got.edge_seen);
        compare_field("tdata padding", 0, out_tdata[OUT_TDATA_W-1:OUT_RAW_W]);
      end
    end
    out_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
  end

  // Send one request; hold it until accepted, then record the expected reading.
  task automatic send_request(item_cmd_t cmd, logic [CAP_W-1:0] count);
    while (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= count;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back(advance_estimator(cmd, count));
    requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Write all four registers while the block is idle.
  task automatic program_settings(logic [CLK_W-1:0] clock_hz, logic [PRE_W-1:0] prescaler,
                                  logic [CAP_W-1:0] period, logic [EPR_W-1:0] edges);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_CLOCK_HZ;
    cfg_wdata <= CFG_W'(clock_hz);
    @(posedge clk);
    set_clock_hz = clock_hz;
    cfg_index <= REG_PRESCALER;
    cfg_wdata <= CFG_W'(prescaler);
    @(posedge clk);
    set_prescaler = prescaler;
    cfg_index <= REG_COUNTER_PERIOD;
    cfg_wdata <= CFG_W'(period);
    @(posedge clk);
    set_period = period;
    cfg_index <= REG_EDGES_PER_REV;
    cfg_wdata <= CFG_W'(edges);
    @(posedge clk);
    set_edges = edges;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset defaults: standstill fallback, zero count, saturation, spike bounds, tick timeout.
  task automatic test_startup_fallback;
    send_request(CMD_TICK, 16'hFFFF);     // tick ignores its count
    send_request(CMD_CAPTURE, 16'd1000);  // from standstill: counter-period speed
    send_request(CMD_CAPTURE, 16'd1000);  // now from the capture itself
    send_request(CMD_CAPTURE, 16'd0);     // zero count: speed zero, spike
    send_request(CMD_CAPTURE, 16'd2000);  // fallback again, no jump from a zero reference
    send_request(CMD_CAPTURE, 16'd1);     // saturates
    send_request(CMD_CAPTURE, 16'hFFFF);  // widest jump, spike upward
    send_request(CMD_CAPTURE, 16'd32767); // exactly half: no spike
    send_request(CMD_CAPTURE, 16'd65534); // exactly twice: no spike
    send_request(CMD_CAPTURE, 16'd32766); // just below half: spike
    send_request(CMD_TICK, 16'd0);        // edge seen: speed kept, flag cleared
    send_request(CMD_TICK, 16'h5A5A);     // no edge: speed cleared
  endtask

  // Registers at their extremes, including zero clock and zero edges per revolution.
  task automatic test_register_extremes;
    // Zero clock: every speed is zero.
    program_settings('0, '0, '1, EDGES_PER_REV_RST);
    send_request(CMD_CAPTURE, 16'd100);
    send_request(CMD_CAPTURE, 16'hFFFF);
    // Widest clock and prescaler, zero edges: divisor vanishes; nonzero counts saturate.
    program_settings('1, '1, '1, '0);
    send_request(CMD_CAPTURE, 16'h8000);
    send_request(CMD_CAPTURE, 16'h0000);
    send_request(CMD_CAPTURE, 16'h7FFF);
    // Zero counter period: ticks clear the speed; the fallback gives zero, so it stays zero.
    program_settings(CLOCK_HZ_RST, '0, '0, 8'd1);
    send_request(CMD_TICK, 16'd0);
    send_request(CMD_TICK, 16'd0);
    send_request(CMD_CAPTURE, 16'd1);
    send_request(CMD_CAPTURE, 16'd2);
    // Slowest possible: truncates to zero.
    program_settings(CLK_W'(1), '1, '1, '1);
    send_request(CMD_CAPTURE, 16'hFFFF);
    // Fastest possible: saturates from the fallback onward.
    program_settings('1, '0, CAP_W'(1), 8'd1);
    send_request(CMD_TICK, 16'd0);
    send_request(CMD_TICK, 16'd0);
    send_request(CMD_CAPTURE, 16'd1);
  endtask

  task automatic program_random_settings;
    logic [CLK_W-1:0] clock_hz;
    logic [PRE_W-1:0] prescaler;
    logic [CAP_W-1:0] period;
    logic [EPR_W-1:0] edges;
    case ($urandom_range(7))
      0:       clock_hz = '1;
      1:       clock_hz = CLK_W'(1);
      default: clock_hz = CLK_W'($urandom_range(268435455, 1000000));
    endcase
    case ($urandom_range(3))
      0:       prescaler = '0;
      1:       prescaler = PRE_W'($urandom);
      default: prescaler = PRE_W'($urandom_range(64, 1));
    endcase
    case ($urandom_range(7))
      0:       period = '0;
      1, 2:    period = '1;
      default: period = CAP_W'($urandom_range(65535, 1));
    endcase
    case ($urandom_range(15))
      0:       edges = '0;
      1:       edges = '1;
      default: edges = EPR_W'($urandom_range(255, 1));
    endcase
    program_settings(clock_hz, prescaler, period, edges);
  endtask

  // Mostly steady rotation with jitter, occasional spikes and stops, plus raw noise.
  task automatic run_motor_traffic(int n_items);
    int               stop_at;
    int               base;
    int               span;
    int               val;
    int               run_len;
    logic [CAP_W-1:0] count;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          // noise: any command, any count
          send_request(item_cmd_t'($urandom_range(1)), CAP_W'($urandom));
        end
        3: begin
          send_request(CMD_CAPTURE, ($urandom_range(1)) ? '0 : '1);
        end
        default: begin
          base = ($urandom_range(3) == 0) ? int'($urandom_range(65535, 1))
                                          : int'($urandom_range(4000, 20));
          span = base / 8;
          run_len = $urandom_range(12, 2);
          for (int k = 0; k < run_len; k++) begin
            val = base + int'($urandom_range(2 * span)) - span;
            if (val < 1) val = 1;
            if (val > 65535) val = 65535;
            count = CAP_W'(val);
            // sporadic glitch in the interval
            if ($urandom_range(15) == 0) count = CAP_W'($urandom);
            send_request(CMD_CAPTURE, count);
            if ($urandom_range(3) == 0) send_request(CMD_TICK, CAP_W'($urandom));
          end
          // stall: two ticks without an edge clear the speed
          if ($urandom_range(2) == 0) begin
            send_request(CMD_TICK, CAP_W'($urandom));
            send_request(CMD_TICK, CAP_W'($urandom));
          end
        end
      endcase
    end
  endtask

  // Two register settings per idling pattern.
  task automatic test_random_traffic;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 17;
          recv_stall_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        program_random_settings();
        run_motor_traffic(ITEMS_PER_SEGMENT);
      end
    end
  endtask

  initial begin
    // Hold reset, then release.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 17;
    recv_stall_pct = 63;
    test_startup_fallback();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    // Let any straggling result surface past one full capture latency.
    repeat (40 + FRAC_BITS + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hall_capture_speed_estimator_tb: clean");
    end else begin
      $display("hall_capture_speed_estimator_tb: errors");
    end
    $finish;
  end

endmodule
